/* rtl/v3mu_pkg.sv */
// Shared constants, types and a rounding helper for the vector math unit.
package v3mu_pkg;

  localparam int unsigned LANE_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned PROD_W     = 2 * LANE_W;
  localparam int unsigned CRS_W      = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned RND_W      = SUM_W + 1;
  localparam int unsigned SHR_W      = RND_W - FRAC_BITS;
  localparam int unsigned ROOT_W     = LANE_W + 1;
  localparam int unsigned SQ_STEPS   = PROD_W / 2;
  localparam int unsigned REM_W      = LANE_W + 4;
  localparam int unsigned NUM_W      = LANE_W + FRAC_BITS;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned SQ_LAT     = SQ_STEPS + 1;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 1;
  localparam int unsigned FRONT_LAT  = 3;
  localparam int unsigned PIPE_DEPTH = FRONT_LAT + SQ_LAT + DIV_LAT;

  localparam logic [LANE_W-1:0] LANE_MAX = {1'b0, {(LANE_W-1){1'b1}}};
  localparam logic [LANE_W-1:0] LANE_MIN = {1'b1, {(LANE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ACT_DOT   = 3'd0,
    ACT_CROSS = 3'd1,
    ACT_LSQ   = 3'd2,
    ACT_LEN   = 3'd3,
    ACT_NORM  = 3'd4,
    ACT_EQ    = 3'd5,
    ACT_NE    = 3'd6,
    ACT_NEAR  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    REG_TOL_X = 2'd0,
    REG_TOL_Y = 2'd1,
    REG_TOL_Z = 2'd2
  } reg_e;

  typedef struct packed {
    logic [LANE_W-1:0] val;
    logic              ov;
  } lane_t;

  typedef struct packed {
    action_e                             act;
    logic [NUM_LANES-1:0][LANE_W-1:0]    a;
    logic [NUM_LANES-1:0][LANE_W-1:0]    fast;
    logic                                fast_ov;
    logic                                flag;
  } lna_t;

  typedef struct packed {
    action_e                             act;
    logic [NUM_LANES-1:0][LANE_W-1:0]    fast;
    logic                                fast_ov;
    logic                                flag;
    logic [ROOT_W-1:0]                   root;
  } lnb_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][LANE_W-1:0]    lanes;
    logic                                flag;
    logic                                ov;
  } res_t;

  // round to nearest (ties up), drop fraction, saturate to lane
  function automatic lane_t round_sat(input logic signed [RND_W-1:0] x);
    logic [RND_W-1:0] t;
    logic [SHR_W-1:0] s;
    lane_t            r;
    t = x + RND_W'(64'd1 << (FRAC_BITS - 1));
    s = t[RND_W-1:FRAC_BITS];
    if ((&s[SHR_W-1:LANE_W-1]) || (~|s[SHR_W-1:LANE_W-1])) begin
      r.val = s[LANE_W-1:0];
      r.ov  = 1'b0;
    end else begin
      r.val = s[SHR_W-1] ? LANE_MIN : LANE_MAX;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/v3mu_prod_lane.sv */
// One axis lane: products, cross difference and per-axis compares.
module v3mu_prod_lane import v3mu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     self_i,
  input  logic [LANE_W-1:0]        ai_i,
  input  logic [LANE_W-1:0]        aj_i,
  input  logic [LANE_W-1:0]        ak_i,
  input  logic [LANE_W-1:0]        bi_i,
  input  logic [LANE_W-1:0]        bj_i,
  input  logic [LANE_W-1:0]        bk_i,
  input  logic [TOL_W-1:0]         tol_i,
  output logic signed [PROD_W-1:0] sq_o,
  output logic signed [CRS_W-1:0]  crs_o,
  output logic                     eq_o,
  output logic                     near_o
);

  logic signed [PROD_W-1:0] pii_q, pc1_q, pc2_q;
  logic signed [PROD_W-1:0] sq_q;
  logic signed [CRS_W-1:0]  crs_q;
  logic                     eq1_q, near1_q, eq_q, near_q;
  logic signed [LANE_W-1:0] bsel;
  logic signed [LANE_W:0]   diff;
  logic [LANE_W:0]          dmag;

  always_comb begin
    bsel = self_i ? $signed(ai_i) : $signed(bi_i);
    diff = $signed({ai_i[LANE_W-1], ai_i}) - $signed({bi_i[LANE_W-1], bi_i});
    dmag = diff[LANE_W] ? (LANE_W+1)'(-diff) : diff;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pii_q   <= $signed(ai_i) * bsel;
      pc1_q   <= $signed(aj_i) * $signed(bk_i);
      pc2_q   <= $signed(ak_i) * $signed(bj_i);
      eq1_q   <= (ai_i == bi_i);
      near1_q <= (dmag <= (LANE_W+1)'(tol_i));
      sq_q    <= pii_q;
      crs_q   <= CRS_W'(pc1_q) - CRS_W'(pc2_q);
      eq_q    <= eq1_q;
      near_q  <= near1_q;
    end
  end

  assign sq_o   = sq_q;
  assign crs_o  = crs_q;
  assign eq_o   = eq_q;
  assign near_o = near_q;

endmodule

/* rtl/v3mu_sqrt.sv */
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module v3mu_sqrt import v3mu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [PROD_W-1:0] sq_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q  [SQ_STEPS];
  logic [LANE_W-1:0] root_q [SQ_STEPS];
  logic [PROD_W-1:0] rad_q  [SQ_STEPS];
  logic [ROOT_W-1:0] out_q;
  logic [REM_W-1:0]  root_ext;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [LANE_W-1:0] root_in;
    logic [PROD_W-1:0] rad_in;
    logic              ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sq_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end
    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[PROD_W-1 -: 2]};
      trial  = {{(REM_W-LANE_W-2){1'b0}}, root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[LANE_W-2:0], ge};
        rad_q[k]  <= {rad_in[PROD_W-3:0], 2'b00};
      end
    end
  end

  assign root_ext = REM_W'(root_q[SQ_STEPS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= (rem_q[SQ_STEPS-1] > root_ext) ? (ROOT_W'(root_q[SQ_STEPS-1]) + 1'b1)
                                               : ROOT_W'(root_q[SQ_STEPS-1]);
    end
  end

  assign root_o = out_q;

endmodule

/* rtl/v3mu_div_lane.sv */
// One normalize lane: pipelined restoring divide of |c|<<frac by length, sign and saturate.
module v3mu_div_lane import v3mu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [LANE_W-1:0] comp_i,
  input  logic [ROOT_W-1:0] len_i,
  output lane_t             lane_o
);

  logic [ROOT_W-1:0] rem_q  [DIV_STEPS];
  logic [NUM_W-1:0]  quo_q  [DIV_STEPS];
  logic [NUM_W-1:0]  num_q  [DIV_STEPS];
  logic [ROOT_W-1:0] den_q  [DIV_STEPS];
  logic              neg_q  [DIV_STEPS];
  logic              zero_q [DIV_STEPS];
  logic [LANE_W-1:0] mag;
  logic [NUM_W-1:0]  num0, q;
  lane_t             res_d, res_q;

  always_comb begin
    mag  = comp_i[LANE_W-1] ? (-comp_i) : comp_i;
    num0 = {mag, {FRAC_BITS{1'b0}}} + NUM_W'(len_i >> 1);
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [ROOT_W-1:0] rem_in, den_in;
    logic [NUM_W-1:0]  quo_in, num_in;
    logic              neg_in, zero_in, ge;
    logic [ROOT_W:0]   rem_sh, rem_sub;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = num0;
      assign den_in  = len_i;
      assign neg_in  = comp_i[LANE_W-1];
      assign zero_in = (len_i == '0);
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign zero_in = zero_q[k-1];
    end
    always_comb begin
      rem_sh  = {rem_in, num_in[NUM_W-1]};
      ge      = (rem_sh >= {1'b0, den_in});
      rem_sub = rem_sh - {1'b0, den_in};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
        quo_q[k]  <= {quo_in[NUM_W-2:0], ge};
        num_q[k]  <= {num_in[NUM_W-2:0], 1'b0};
        den_q[k]  <= den_in;
        neg_q[k]  <= neg_in;
        zero_q[k] <= zero_in;
      end
    end
  end

  assign q = quo_q[DIV_STEPS-1];

  always_comb begin
    res_d.val = '0;
    res_d.ov  = 1'b0;
    if (!zero_q[DIV_STEPS-1]) begin
      if (neg_q[DIV_STEPS-1]) begin
        if (q > NUM_W'(LANE_MIN)) begin
          res_d.val = LANE_MIN;
          res_d.ov  = 1'b1;
        end else begin
          res_d.val = -q[LANE_W-1:0];
        end
      end else begin
        if (q > NUM_W'(LANE_MAX)) begin
          res_d.val = LANE_MAX;
          res_d.ov  = 1'b1;
        end else begin
          res_d.val = q[LANE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign lane_o = res_q;

endmodule

/* rtl/vector3_math_unit_top.sv */
// Top level of the 3D vector math unit: lanes, root, normalize dividers and merge.
//
//  channel | direction | handshake                    | word
//  in      | in        | in_valid_i / in_ready_o      | action_i, a_*_i, b_*_i
//  out     | out       | out_valid_o / out_ready_i    | r_*_o, flag_o, overflow_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; the path to the output register
// runs through the 32-stage square root and the 48-stage normalize dividers in series.
// Reset clears the valid chain, the output/skid valid flags and the tolerances.
// A stalled output fills the skid register; the pipeline then holds until it drains.
module vector3_math_unit_top import v3mu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [LANE_W-1:0] a_x_i,
  input  logic [LANE_W-1:0] a_y_i,
  input  logic [LANE_W-1:0] a_z_i,
  input  logic [LANE_W-1:0] a_w_i,
  input  logic [LANE_W-1:0] b_x_i,
  input  logic [LANE_W-1:0] b_y_i,
  input  logic [LANE_W-1:0] b_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LANE_W-1:0] r_x_o,
  output logic [LANE_W-1:0] r_y_o,
  output logic [LANE_W-1:0] r_z_o,
  output logic [LANE_W-1:0] r_w_o,
  output logic              flag_o,
  output logic              overflow_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [LANE_W-1:0] cfg_data_i
);

  logic                              en;
  logic [PIPE_DEPTH-1:0]             vld_q;
  logic [TOL_W-1:0]                  tol_q [NUM_AXES];
  logic [NUM_LANES-1:0][LANE_W-1:0]  a_in;
  logic [NUM_AXES-1:0][LANE_W-1:0]   b_in;
  action_e                           act_in;
  logic                              self_sel;

  action_e                           act_s1_q, act_s2_q, act_s3_q;
  logic [NUM_LANES-1:0][LANE_W-1:0]  a_s1_q, a_s2_q, a_s3_q;
  logic signed [PROD_W-1:0]          sq_w   [NUM_AXES];
  logic signed [CRS_W-1:0]           crs_w  [NUM_AXES];
  logic [NUM_AXES-1:0]               eq_w, near_w;
  logic signed [SUM_W-1:0]           sum_q;
  lane_t                             crs_q  [NUM_AXES];
  logic                              flag_s3_q;

  lna_t                              lna_d;
  lna_t                              lna_q  [SQ_LAT];
  lnb_t                              lnb_q  [DIV_LAT];
  logic [ROOT_W-1:0]                 root;
  lane_t                             div_res [NUM_LANES];
  lane_t                             dot;
  lnb_t                              lb;
  res_t                              res_d, out_q, skid_q;
  logic                              out_valid_q, skid_valid_q, out_take, tail_vld;

  assign a_in   = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign b_in   = {b_z_i, b_y_i, b_x_i};
  assign act_in = action_e'(action_i);

  always_comb begin
    self_sel = act_in inside {ACT_LSQ, ACT_LEN, ACT_NORM};
  end

  assign en          = !skid_valid_q;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // tolerance registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        tol_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_TOL_X: tol_q[0] <= cfg_data_i[TOL_W-1:0];
        REG_TOL_Y: tol_q[1] <= cfg_data_i[TOL_W-1:0];
        REG_TOL_Z: tol_q[2] <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3mu_prod_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .self_i (self_sel),
      .ai_i   (a_in[i]),
      .aj_i   (a_in[J]),
      .ak_i   (a_in[K]),
      .bi_i   (b_in[i]),
      .bj_i   (b_in[J]),
      .bk_i   (b_in[K]),
      .tol_i  (tol_q[i]),
      .sq_o   (sq_w[i]),
      .crs_o  (crs_w[i]),
      .eq_o   (eq_w[i]),
      .near_o (near_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act_s1_q <= act_in;
      act_s2_q <= act_s1_q;
      act_s3_q <= act_s2_q;
      a_s1_q   <= a_in;
      a_s2_q   <= a_s1_q;
      a_s3_q   <= a_s2_q;
      sum_q    <= SUM_W'(sq_w[0]) + SUM_W'(sq_w[1]) + SUM_W'(sq_w[2]);
      for (int i = 0; i < NUM_AXES; i++) begin
        crs_q[i] <= round_sat(RND_W'(crs_w[i]));
      end
      case (act_s2_q)
        ACT_EQ:   flag_s3_q <= &eq_w;
        ACT_NE:   flag_s3_q <= ~&eq_w;
        ACT_NEAR: flag_s3_q <= &near_w;
        default:  flag_s3_q <= 1'b0;
      endcase
    end
  end

  always_comb begin
    dot           = round_sat(RND_W'(sum_q));
    lna_d.act     = act_s3_q;
    lna_d.a       = a_s3_q;
    lna_d.flag    = flag_s3_q;
    lna_d.fast    = '0;
    lna_d.fast_ov = 1'b0;
    case (act_s3_q)
      ACT_DOT, ACT_LSQ: begin
        lna_d.fast    = {NUM_LANES{dot.val}};
        lna_d.fast_ov = dot.ov;
      end
      ACT_CROSS: begin
        lna_d.fast    = {{LANE_W{1'b0}}, crs_q[2].val, crs_q[1].val, crs_q[0].val};
        lna_d.fast_ov = crs_q[0].ov | crs_q[1].ov | crs_q[2].ov;
      end
      default: ;
    endcase
  end

  v3mu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (sum_q[PROD_W-1:0]),
    .root_o (root)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_div
    v3mu_div_lane u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .comp_i (lna_q[SQ_LAT-1].a[i]),
      .len_i  (root),
      .lane_o (div_res[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lna_q[0]          <= lna_d;
      lnb_q[0].act      <= lna_q[SQ_LAT-1].act;
      lnb_q[0].fast     <= lna_q[SQ_LAT-1].fast;
      lnb_q[0].fast_ov  <= lna_q[SQ_LAT-1].fast_ov;
      lnb_q[0].flag     <= lna_q[SQ_LAT-1].flag;
      lnb_q[0].root     <= root;
      for (int k = 1; k < SQ_LAT; k++) begin
        lna_q[k] <= lna_q[k-1];
      end
      for (int k = 1; k < DIV_LAT; k++) begin
        lnb_q[k] <= lnb_q[k-1];
      end
    end
  end

  // merge
  assign lb = lnb_q[DIV_LAT-1];

  always_comb begin
    res_d.lanes = lb.fast;
    res_d.ov    = lb.fast_ov;
    res_d.flag  = lb.flag;
    case (lb.act)
      ACT_LEN: begin
        if (lb.root > ROOT_W'(LANE_MAX)) begin
          res_d.lanes = {NUM_LANES{LANE_MAX}};
          res_d.ov    = 1'b1;
        end else begin
          res_d.lanes = {NUM_LANES{lb.root[LANE_W-1:0]}};
          res_d.ov    = 1'b0;
        end
      end
      ACT_NORM: begin
        res_d.lanes = {div_res[3].val, div_res[2].val, div_res[1].val, div_res[0].val};
        res_d.ov    = div_res[0].ov | div_res[1].ov | div_res[2].ov | div_res[3].ov;
      end
      default: ;
    endcase
  end

  // output register with skid
  assign tail_vld = vld_q[PIPE_DEPTH-1];
  assign out_take = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= tail_vld;
      end
    end else if (!skid_valid_q && tail_vld) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (!skid_valid_q) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign r_x_o       = out_q.lanes[0];
  assign r_y_o       = out_q.lanes[1];
  assign r_z_o       = out_q.lanes[2];
  assign r_w_o       = out_q.lanes[3];
  assign flag_o      = out_q.flag;
  assign overflow_o  = out_q.ov;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  a_skid_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !in_ready_o)
    else $error("input accepted while skid is full");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid filled without an output stall");

  a_flag_no_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flag_o) |-> !overflow_o)
    else $error("compare word reports overflow");

endmodule
